// ===== rtl/c8ic_pkg.sv =====
// Package for the CHIP-8 style instruction core.
// Holds the word types, operation and status codes, sizes and the hex font.
// No dependencies.
`timescale 1ns / 1ps
package c8ic_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int PROGRAM_START = 512;
  localparam int FONT_BASE     = 80;
  localparam int STACK_DEPTH   = 16;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int FONT_BYTES    = 80;
  localparam int ADDR_W        = $clog2(MEM_BYTES);
  localparam int SP_W          = $clog2(STACK_DEPTH);
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EXEC = 2'd1;
  localparam logic [1:0] OP_ROW  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [1:0] STAT_WAIT    = 2'd2;
  localparam logic [1:0] STAT_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [15:0] key_state;
    logic [7:0]  random_byte;
    logic [4:0]  row_select;
  } in_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [11:0] index_value;
    logic [1:0]  status;
    logic [63:0] row_pixels;
  } out_t;

  localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage

// ===== rtl/chip8_instruction_core_top.sv =====
// CHIP-8 style instruction core: one input word loads a byte, executes one
// instruction or reads a frame buffer row, and yields one output word with PC,
// I, status and the selected row. After reset the core runs a clearing pass
// over all of main memory (zeros plus the font) and the data registers before
// it takes the first word. It takes no new word until the last has gone to the
// output register. An instruction fetches its two bytes, reads Vx and Vy and
// executes; a VF flag (8xy4-8xyE), sprite rows, Fx33 and Fx55/Fx65 add states.
// Main memory and the data register RAM each have a single port, so these steps
// touch them one access at a time; a stalled output holds the core in S_OUT.
// Depends on c8ic_pkg and c8ic_ram.
`timescale 1ns / 1ps
module chip8_instruction_core_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  c8ic_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output c8ic_pkg::out_t out_o
);
  import c8ic_pkg::*;

  typedef enum logic [16:0] {
    S_CLR  = 17'h00001,
    S_IDLE = 17'h00002,
    S_OPLO = 17'h00004,
    S_DEC  = 17'h00008,
    S_RX   = 17'h00010,
    S_RY   = 17'h00020,
    S_EXEC = 17'h00040,
    S_VF   = 17'h00080,
    S_DRD  = 17'h00100,
    S_DWR  = 17'h00200,
    S_BCD  = 17'h00400,
    S_SRD  = 17'h00800,
    S_SWR  = 17'h01000,
    S_LRD  = 17'h02000,
    S_LWR  = 17'h04000,
    S_ROW  = 17'h08000,
    S_OUT  = 17'h10000
  } state_e;

  state_e              state_q, state_d;
  in_t                 item_q, item_d;
  logic [ADDR_W-1:0]   pc_q, pc_d, i_q, i_d, clr_q, clr_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic [ADDR_W-1:0]   stack_q [STACK_DEPTH];
  logic [ADDR_W-1:0]   push_val;
  logic                push;
  logic [7:0]          timer_q, timer_d, hi_q, hi_d, va_q, va_d, vb_q, vb_d;
  logic [15:0]         op_q, op_d;
  logic [1:0]          status_q, status_d;
  logic [3:0]          cnt_q, cnt_d;
  logic                flag_q, flag_d;
  logic [SCREEN_HEIGHT-1:0] vld_q, vld_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic [ADDR_W-1:0]   mm_addr;
  logic                mem_we;
  logic [7:0]          mem_wdata, mem_rdata;
  logic [3:0]          v_addr;
  logic                v_we;
  logic [7:0]          v_wdata, v_rdata;
  logic [ROW_W-1:0]    fb_addr;
  logic                fb_we;
  logic [63:0]         fb_wdata, fb_rdata;

  logic [3:0]          x, y, n;
  logic [7:0]          kk;
  logic [ADDR_W-1:0]   nnn, pc_next, pc_skip, i_plus;
  logic [8:0]          sum9;
  logic [ADDR_W-1:0]   font_off;
  logic                in_font;
  logic [ROW_W-1:0]    draw_row;
  logic [63:0]         old_row, spr_bits;
  logic [127:0]        spr_wide;
  logic [1:0]          bcd_h;
  logic [7:0]          bcd_r, bcd_t, bcd_o;
  logic [15:0]         bcd_m;
  logic [3:0]          low_key;
  logic [SP_W-1:0]     sp_dec, sp_inc;

  assign x   = op_q[11:8];
  assign y   = op_q[7:4];
  assign n   = op_q[3:0];
  assign kk  = op_q[7:0];
  assign nnn = op_q[11:0];
  assign pc_next = pc_q + ADDR_W'(2);
  assign pc_skip = pc_q + ADDR_W'(4);
  assign i_plus  = i_q + ADDR_W'(cnt_q);
  assign sum9    = {1'b0, va_q} + {1'b0, vb_q};
  assign sp_dec  = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - SP_W'(1);
  assign sp_inc  = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + SP_W'(1);

  assign font_off = clr_q - ADDR_W'(FONT_BASE);
  assign in_font  = (clr_q >= ADDR_W'(FONT_BASE)) && (font_off < ADDR_W'(FONT_BYTES));

  assign draw_row = vb_q[ROW_W-1:0] + ROW_W'(cnt_q);
  assign old_row  = vld_q[draw_row] ? fb_rdata : '0;
  assign spr_wide = {mem_rdata, 56'd0, mem_rdata, 56'd0} >> va_q[5:0];
  assign spr_bits = spr_wide[63:0];

  // Decimal digits of Vx: hundreds by compare, tens by reciprocal multiply.
  assign bcd_h = (va_q >= 8'd200) ? 2'd2 : (va_q >= 8'd100) ? 2'd1 : 2'd0;
  assign bcd_r = va_q - 8'(bcd_h) * 8'd100;
  assign bcd_m = 16'(bcd_r) * 16'd205;
  assign bcd_t = 8'(bcd_m >> 11);
  assign bcd_o = bcd_r - 8'(bcd_t * 8'd10);

  always_comb begin
    low_key = '0;
    for (int k = 15; k >= 0; k--) begin
      if (item_q.key_state[k]) begin
        low_key = 4'(k);
      end
    end
  end

  always_comb begin
    state_d = state_q;  item_d = item_q;  pc_d = pc_q;  i_d = i_q;  clr_d = clr_q;
    sp_d = sp_q;  timer_d = timer_q;  hi_d = hi_q;  va_d = va_q;  vb_d = vb_q;
    op_d = op_q;  status_d = status_q;  cnt_d = cnt_q;  flag_d = flag_q;
    vld_d = vld_q;  out_valid_d = out_valid_q;  out_d = out_q;
    push = 1'b0;  push_val = pc_next;
    mm_addr = pc_q;  mem_we = 1'b0;  mem_wdata = '0;
    v_addr = x;  v_we = 1'b0;  v_wdata = '0;
    fb_addr = item_q.row_select;  fb_we = 1'b0;  fb_wdata = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        mm_addr   = clr_q;
        mem_we    = 1'b1;
        mem_wdata = in_font ? GLYPHS[font_off[6:0]] : 8'd0;
        v_addr    = clr_q[3:0];
        v_we      = 1'b1;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(MEM_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d   = in_i;
          status_d = STAT_OK;
          state_d  = S_ROW;
          case (in_i.operation)
            OP_LOAD: begin
              mm_addr   = in_i.load_address;
              mem_we    = 1'b1;
              mem_wdata = in_i.load_data;
            end
            OP_EXEC: begin
              if (timer_q != '0) begin
                timer_d = timer_q - 8'd1;
              end
              state_d = S_OPLO;
            end
            default: ;
          endcase
        end
      end
      S_OPLO: begin
        hi_d    = mem_rdata;
        mm_addr = pc_q + ADDR_W'(1);
        state_d = S_DEC;
      end
      S_DEC: begin
        op_d    = {hi_q, mem_rdata};
        v_addr  = (hi_q[7:4] == 4'hB) ? 4'h0 : hi_q[3:0];
        state_d = S_RX;
      end
      S_RX: begin
        va_d    = v_rdata;
        v_addr  = y;
        state_d = S_RY;
      end
      S_RY: begin
        vb_d    = v_rdata;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        pc_d    = pc_next;
        state_d = S_ROW;
        case (op_q[15:12])
          4'h0: begin
            if (op_q == 16'h00E0) begin
              vld_d = '0;
            end else if (op_q == 16'h00EE) begin
              sp_d = sp_dec;
              pc_d = stack_q[sp_dec];
            end else begin
              status_d = STAT_UNKNOWN;
            end
          end
          4'h1: pc_d = nnn;
          4'h2: begin
            push = 1'b1;
            sp_d = sp_inc;
            pc_d = nnn;
          end
          4'h3: if (va_q == kk) pc_d = pc_skip;
          4'h4: if (va_q != kk) pc_d = pc_skip;
          4'h5: if (va_q == vb_q) pc_d = pc_skip;
          4'h9: if (va_q != vb_q) pc_d = pc_skip;
          4'h6: begin
            v_we = 1'b1;  v_wdata = kk;
          end
          4'h7: begin
            v_we = 1'b1;  v_wdata = va_q + kk;
          end
          4'h8: begin
            v_we = 1'b1;
            case (n)
              4'h0: v_wdata = vb_q;
              4'h1: v_wdata = va_q | vb_q;
              4'h2: v_wdata = va_q & vb_q;
              4'h3: v_wdata = va_q ^ vb_q;
              4'h4: begin
                v_wdata = sum9[7:0];  flag_d = sum9[8];  state_d = S_VF;
              end
              4'h5: begin
                v_wdata = va_q - vb_q;  flag_d = va_q > vb_q;  state_d = S_VF;
              end
              4'h6: begin
                v_wdata = {1'b0, va_q[7:1]};  flag_d = va_q[0];  state_d = S_VF;
              end
              4'h7: begin
                v_wdata = vb_q - va_q;  flag_d = vb_q > va_q;  state_d = S_VF;
              end
              4'hE: begin
                v_wdata = {va_q[6:0], 1'b0};  flag_d = va_q[7];  state_d = S_VF;
              end
              default: begin
                v_we = 1'b0;  status_d = STAT_UNKNOWN;
              end
            endcase
          end
          4'hA: i_d = nnn;
          4'hB: pc_d = nnn + ADDR_W'(va_q);
          4'hC: begin
            v_we = 1'b1;  v_wdata = item_q.random_byte & kk;
          end
          4'hD: begin
            cnt_d   = '0;
            flag_d  = 1'b0;
            state_d = (n == '0) ? S_VF : S_DRD;
          end
          4'hE: begin
            if (kk == 8'h9E) begin
              if (item_q.key_state[va_q[3:0]]) pc_d = pc_skip;
            end else if (kk == 8'hA1) begin
              if (!item_q.key_state[va_q[3:0]]) pc_d = pc_skip;
            end else begin
              status_d = STAT_UNKNOWN;
            end
          end
          default: begin
            cnt_d = '0;
            case (kk)
              8'h07: begin
                v_we = 1'b1;  v_wdata = timer_q;
              end
              8'h0A: begin
                if (item_q.key_state == '0) begin
                  pc_d = pc_q;  status_d = STAT_WAIT;
                end else begin
                  v_we = 1'b1;  v_wdata = {4'd0, low_key};
                end
              end
              8'h15: timer_d = va_q;
              8'h18: ;
              8'h1E: i_d = i_q + ADDR_W'(va_q);
              8'h29: i_d = ADDR_W'(FONT_BASE) + ADDR_W'(va_q[3:0]) * ADDR_W'(5);
              8'h33: state_d = S_BCD;
              8'h55: state_d = S_SRD;
              8'h65: state_d = S_LRD;
              default: status_d = STAT_UNKNOWN;
            endcase
          end
        endcase
      end
      S_VF: begin
        v_addr  = 4'hF;
        v_we    = 1'b1;
        v_wdata = {7'd0, flag_q};
        state_d = S_ROW;
      end
      S_DRD: begin
        mm_addr = i_plus;
        fb_addr = draw_row;
        state_d = S_DWR;
      end
      S_DWR: begin
        fb_addr  = draw_row;
        fb_we    = 1'b1;
        fb_wdata = old_row ^ spr_bits;
        vld_d[draw_row] = 1'b1;
        flag_d   = flag_q | (|(old_row & spr_bits));
        if (cnt_q == n - 4'd1) begin
          state_d = S_VF;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = S_DRD;
        end
      end
      S_BCD: begin
        mm_addr = i_plus;
        mem_we  = 1'b1;
        case (cnt_q[1:0])
          2'd0:    mem_wdata = {6'd0, bcd_h};
          2'd1:    mem_wdata = bcd_t;
          default: mem_wdata = bcd_o;
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2) begin
          state_d = S_ROW;
        end
      end
      S_SRD: begin
        v_addr  = cnt_q;
        state_d = S_SWR;
      end
      S_SWR: begin
        mm_addr   = i_plus;
        mem_we    = 1'b1;
        mem_wdata = v_rdata;
        cnt_d     = cnt_q + 4'd1;
        state_d   = (cnt_q == x) ? S_ROW : S_SRD;
      end
      S_LRD: begin
        mm_addr = i_plus;
        state_d = S_LWR;
      end
      S_LWR: begin
        v_addr  = cnt_q;
        v_we    = 1'b1;
        v_wdata = mem_rdata;
        cnt_d   = cnt_q + 4'd1;
        state_d = (cnt_q == x) ? S_ROW : S_LRD;
      end
      S_ROW: state_d = S_OUT;
      S_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d.program_counter = pc_q;
          out_d.index_value     = i_q;
          out_d.status          = status_q;
          out_d.row_pixels      = vld_q[item_q.row_select] ? fb_rdata : '0;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      pc_q        <= ADDR_W'(PROGRAM_START);
      i_q         <= '0;
      clr_q       <= '0;
      sp_q        <= '0;
      timer_q     <= '0;
      status_q    <= STAT_OK;
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < STACK_DEPTH; k++) begin
        stack_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      i_q         <= i_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      timer_q     <= timer_d;
      status_q    <= status_d;
      cnt_q       <= cnt_d;
      flag_q      <= flag_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      if (push) begin
        stack_q[sp_q] <= push_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    hi_q   <= hi_d;
    op_q   <= op_d;
    va_q   <= va_d;
    vb_q   <= vb_d;
    out_q  <= out_d;
  end

  c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
    .clk_i(clk_i), .addr_i(mm_addr), .we_i(mem_we), .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
    .clk_i(clk_i), .addr_i(v_addr), .we_i(v_we), .wdata_i(v_wdata),
    .rdata_o(v_rdata)
  );

  c8ic_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_fb (
    .clk_i(clk_i), .addr_i(fb_addr), .we_i(fb_we), .wdata_i(fb_wdata),
    .rdata_o(fb_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/c8ic_ram.sv =====
// Generic single-port RAM with registered read data.
// Used for main memory, data registers and frame buffer. No dependencies.
`timescale 1ns / 1ps
module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/c8ic_checker.sv =====
// Port-level checks for the CHIP-8 style instruction core, bound to the top.
// Depends on c8ic_pkg.
`timescale 1ns / 1ps
module c8ic_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input c8ic_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input c8ic_pkg::out_t out_o
);
  import c8ic_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_o))
    else $error("output word changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.status != STAT_NONE)
    else $error("status code out of range");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken before the first finished");

endmodule

bind chip8_instruction_core_top c8ic_checker u_c8ic_checker (.*);
